// ===== src/tmte_pkg.sv =====
package tmte_pkg;

   localparam logic [2:0] KIND_PUT_CHAR = 3'd0;
   localparam logic [2:0] KIND_PUT_AT   = 3'd1;
   localparam logic [2:0] KIND_MOVE     = 3'd2;
   localparam logic [2:0] KIND_CLEAR    = 3'd3;
   localparam logic [2:0] KIND_READ     = 3'd4;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   localparam logic [7:0] COLOUR_RESET = 8'h0F;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] char_code;
      logic [7:0] cell_colour;
      logic [6:0] column;
      logic [4:0] row;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_offset;
      logic [15:0] cell_value;
   } rsp_type;

endpackage

// ===== src/tmte_cursor.sv =====
module tmte_cursor #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  tmte_pkg::req_type                item,
   output logic [$clog2(SCREEN_WIDTH)-1:0]  cursor_col,
   output logic [$clog2(SCREEN_HEIGHT)-1:0] cursor_line,
   output logic                             put_write,
   output logic                             put_scroll
);

   localparam int CW = $clog2(SCREEN_WIDTH);
   localparam int LW = $clog2(SCREEN_HEIGHT);
   localparam logic [8:0]    WIDTH_9   = 9'(SCREEN_WIDTH);
   localparam logic [7:0]    HEIGHT_8  = 8'(SCREEN_HEIGHT);
   localparam logic [CW:0]   WIDTH_W   = (CW+1)'(SCREEN_WIDTH);
   localparam logic [LW:0]   HEIGHT_W  = (LW+1)'(SCREEN_HEIGHT);
   localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_WIDTH - 1);
   localparam logic [LW-1:0] LAST_LINE = LW'(SCREEN_HEIGHT - 1);

   logic [CW-1:0] col_ff, col_in;
   logic [LW-1:0] line_ff, line_in;
   logic          is_newline, is_tab, wrap;
   logic [CW:0]   put_col;
   logic [LW:0]   put_line;
   logic [CW-1:0] put_col_final;
   logic [LW-1:0] put_line_final;

   always_comb begin
      is_newline = item.char_code == tmte_pkg::CH_NEWLINE;
      is_tab     = item.char_code == tmte_pkg::CH_TAB;
      if (is_newline) begin
         put_col = '0;
      end else if (is_tab) begin
         put_col = ((({1'b0, col_ff} >> 2) + (CW+1)'(1)) << 2);
      end else begin
         put_col = {1'b0, col_ff} + (CW+1)'(1);
      end
      wrap       = put_col >= WIDTH_W;
      put_line   = {1'b0, line_ff} + (LW+1)'(is_newline | wrap);
      put_scroll = put_line >= HEIGHT_W;
      put_write  = !is_newline && !is_tab;
      put_col_final  = wrap ? '0 : put_col[CW-1:0];
      put_line_final = put_scroll ? LAST_LINE : put_line[LW-1:0];
   end

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      if (accept) begin
         unique case (item.kind)
            tmte_pkg::KIND_PUT_CHAR: begin
               col_in  = put_col_final;
               line_in = put_line_final;
            end
            tmte_pkg::KIND_MOVE: begin
               col_in  = ({2'b0, item.column} < WIDTH_9) ? CW'(item.column) : LAST_COL;
               line_in = ({3'b0, item.row} < HEIGHT_8) ? LW'(item.row) : LAST_LINE;
            end
            tmte_pkg::KIND_CLEAR: begin
               col_in  = '0;
               line_in = '0;
            end
            default: begin
               col_in  = col_ff;
               line_in = line_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
      end else begin
         col_ff  <= col_in;
         line_ff <= line_in;
      end
   end

   assign cursor_col  = col_ff;
   assign cursor_line = line_ff;

endmodule

// ===== src/text_mode_terminal_engine_core.sv =====
// Text-mode terminal engine: a SCREEN_WIDTH x SCREEN_HEIGHT screen of 16-bit
// cells (attribute high byte, character low byte) kept in one block RAM with
// a registered read port, plus a cursor.
// Input: raise start with req_item; the item is taken at a clock edge where
// busy is low. Output: one item per input on rsp_item, marked by rsp_strobe
// for exactly one cycle, the cycle after the input was taken; the receiver
// cannot stall and must take it then.
// Put characters that do not scroll, put at, move, read and unused kinds
// leave busy low, so such items can follow back to back. A put character
// that scrolls keeps busy high while the copy walk moves each row up one
// row and the fill walk writes spaces in the text colour to the last row;
// clear keeps it high while the fill walk writes spaces to every cell. The
// RAM has one write and one read port, which sets the one cell per cycle
// pace of those walks. Reset zeroes the cursor, sets text colour to 15 and
// then zeroes the screen with busy high. csr_we writes the text colour at
// once; write it only while the block is idle.
module text_mode_terminal_engine_core #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tmte_pkg::req_type req_item,
   output logic              rsp_strobe,
   output tmte_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata
);

   localparam int CW         = $clog2(SCREEN_WIDTH);
   localparam int LW         = $clog2(SCREEN_HEIGHT);
   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam logic [AW-1:0] COPY_LAST  = AW'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
   localparam logic [AW-1:0] CELL_LAST  = AW'(CELL_COUNT - 1);
   localparam logic [AW:0]   WIDTH_A    = (AW+1)'(SCREEN_WIDTH);
   localparam logic [8:0]    WIDTH_9    = 9'(SCREEN_WIDTH);
   localparam logic [7:0]    HEIGHT_8   = 8'(SCREEN_HEIGHT);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COPY,
      S_FILL
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] cnt_ff;
   logic [15:0]   fill_data_ff;
   logic          rsp_strobe_ff;
   logic          rd_flag_ff;
   logic [7:0]    colour_ff;
   logic [15:0]   rd_q_ff;
   logic [15:0]   screen_mem [CELL_COUNT];

   logic          req_accept;
   logic [CW-1:0] cursor_col;
   logic [LW-1:0] cursor_line;
   logic          put_write, put_scroll;
   logic          on_screen;
   logic [AW:0]   sel_line, sel_col, acc_addr, cursor_off;
   logic          we;
   logic [AW-1:0] wa, ra;
   logic [15:0]   wd;

   assign req_accept = start && !busy;
   assign busy       = state_ff != S_IDLE;

   tmte_cursor #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .item       (req_item),
      .cursor_col (cursor_col),
      .cursor_line(cursor_line),
      .put_write  (put_write),
      .put_scroll (put_scroll)
   );

   always_comb begin
      on_screen = ({2'b0, req_item.column} < WIDTH_9) && ({3'b0, req_item.row} < HEIGHT_8);
      if (req_item.kind == tmte_pkg::KIND_PUT_CHAR) begin
         sel_line = (AW+1)'(cursor_line);
         sel_col  = (AW+1)'(cursor_col);
      end else begin
         sel_line = (AW+1)'(req_item.row);
         sel_col  = (AW+1)'(req_item.column);
      end
      acc_addr   = sel_line * WIDTH_A + sel_col;
      cursor_off = (AW+1)'(cursor_line) * WIDTH_A + (AW+1)'(cursor_col);
   end

   // write port: item write when idle, else the copy or fill walk; read address: the item's cell, or the copy source
   always_comb begin
      we = 1'b0;
      wa = acc_addr[AW-1:0];
      wd = {colour_ff, req_item.char_code};
      ra = acc_addr[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && req_item.kind == tmte_pkg::KIND_PUT_CHAR && put_write) begin
               we = 1'b1;
            end else if (req_accept && req_item.kind == tmte_pkg::KIND_PUT_AT && on_screen) begin
               we = 1'b1;
               wd = {req_item.cell_colour, req_item.char_code};
            end
         end
         S_COPY: begin
            we = cnt_ff != '0;
            wa = cnt_ff - AW'(1);
            wd = rd_q_ff;
            ra = (cnt_ff < COPY_LAST) ? cnt_ff + AW'(SCREEN_WIDTH) : '0;
         end
         S_FILL: begin
            we = 1'b1;
            wa = cnt_ff;
            wd = fill_data_ff;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         screen_mem[wa] <= wd;
      end
      rd_q_ff <= screen_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff <= tmte_pkg::COLOUR_RESET;
      end else if (csr_we) begin
         colour_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         cnt_ff        <= '0;
         fill_data_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
         rd_flag_ff    <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_accept;
         rd_flag_ff    <= req_accept && req_item.kind == tmte_pkg::KIND_READ && on_screen;
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept && req_item.kind == tmte_pkg::KIND_PUT_CHAR && put_scroll) begin
                  state_ff     <= S_COPY;
                  cnt_ff       <= '0;
                  fill_data_ff <= {colour_ff, tmte_pkg::CH_SPACE};
               end else if (req_accept && req_item.kind == tmte_pkg::KIND_CLEAR) begin
                  state_ff     <= S_FILL;
                  cnt_ff       <= '0;
                  fill_data_ff <= {colour_ff, tmte_pkg::CH_SPACE};
               end
            end
            S_COPY: begin
               if (cnt_ff == COPY_LAST) begin
                  state_ff <= S_FILL;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            S_FILL: begin
               if (cnt_ff == CELL_LAST) begin
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_item.cursor_column = 7'(cursor_col);
   assign rsp_item.cursor_row    = 5'(cursor_line);
   assign rsp_item.cursor_offset = 11'(cursor_off);
   assign rsp_item.cell_value    = rd_flag_ff ? rd_q_ff : 16'h0000;

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_strobe)
      else $error("item accepted without a response next cycle");

   a_rsp_has_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept))
      else $error("response without an accepted item");

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (AW+1)'(cursor_col) < WIDTH_A && 8'(cursor_line) < HEIGHT_8)
      else $error("cursor off screen");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> cnt_ff <= COPY_LAST)
      else $error("copy walk past last row");

endmodule

// ===== test/tb_text_mode_terminal_engine_core.sv =====
module tb_text_mode_terminal_engine_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W = 80;
   localparam int SCREEN_H = 25;
   localparam int CELLS = SCREEN_W * SCREEN_H;
   localparam int SCREEN_WALK_CYCLES = 2100;
   localparam int PHASE_ITEMS = 226;
   localparam int PHASE_WALKS = 25;

   typedef struct packed {
      tmte_pkg::req_type req;
      tmte_pkg::rsp_type rsp;
   } terminal_job_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tmte_pkg::req_type req_item = '0;
   logic rsp_strobe;
   tmte_pkg::rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'h00;

   logic [15:0] screen [0:CELLS-1];
   int unsigned cur_col;
   int unsigned cur_row;
   logic [7:0] text_colour;

   terminal_job_type queued_items[$];
   tmte_pkg::rsp_type due_results[$];
   terminal_job_type on_port;
   int pause_left = 0;
   int calm_left = 0;
   int mismatches = 0;

   text_mode_terminal_engine_core #(
      .SCREEN_WIDTH(SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb_text_mode_terminal_engine_core: FAIL");
      $finish;
   end

   task automatic report_mismatch(string what, longint got, longint want);
      if (mismatches < 100) begin
         $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   function automatic tmte_pkg::rsp_type terminal_step(tmte_pkg::req_type r);
      tmte_pkg::rsp_type res;
      int unsigned idx;
      bit on_screen;
      res = '0;
      on_screen = (r.column < SCREEN_W) && (r.row < SCREEN_H);
      case (r.kind)
         tmte_pkg::KIND_PUT_CHAR: begin
            if (r.char_code == tmte_pkg::CH_NEWLINE) begin
               cur_col = 0;
               cur_row++;
            end else if (r.char_code == tmte_pkg::CH_TAB) begin
               cur_col = (cur_col / 4 + 1) * 4;
            end else begin
               screen[cur_row * SCREEN_W + cur_col] = {text_colour, r.char_code};
               cur_col++;
            end
            if (cur_col >= SCREEN_W) begin
               cur_col = 0;
               cur_row++;
            end
            if (cur_row >= SCREEN_H) begin
               for (idx = 0; idx < (SCREEN_H - 1) * SCREEN_W; idx++)
                  screen[idx] = screen[idx + SCREEN_W];
               for (idx = (SCREEN_H - 1) * SCREEN_W; idx < CELLS; idx++)
                  screen[idx] = {text_colour, tmte_pkg::CH_SPACE};
               cur_row = SCREEN_H - 1;
            end
         end
         tmte_pkg::KIND_PUT_AT: begin
            if (on_screen)
               screen[r.row * SCREEN_W + r.column] = {r.cell_colour, r.char_code};
         end
         tmte_pkg::KIND_MOVE: begin
            cur_col = (r.column < SCREEN_W) ? r.column : SCREEN_W - 1;
            cur_row = (r.row < SCREEN_H) ? r.row : SCREEN_H - 1;
         end
         tmte_pkg::KIND_CLEAR: begin
            cur_col = 0;
            cur_row = 0;
            for (idx = 0; idx < CELLS; idx++)
               screen[idx] = {text_colour, tmte_pkg::CH_SPACE};
         end
         tmte_pkg::KIND_READ: begin
            if (on_screen)
               res.cell_value = screen[r.row * SCREEN_W + r.column];
         end
         default: ;
      endcase
      res.cursor_column = 7'(cur_col);
      res.cursor_row = 5'(cur_row);
      res.cursor_offset = 11'(cur_row * SCREEN_W + cur_col);
      return res;
   endfunction

   // clear, or a put character that scrolls
   function automatic bit walks_screen(tmte_pkg::req_type r);
      int unsigned next_col;
      if (r.kind == tmte_pkg::KIND_CLEAR)
         return 1'b1;
      if (r.kind != tmte_pkg::KIND_PUT_CHAR || cur_row != SCREEN_H - 1)
         return 1'b0;
      if (r.char_code == tmte_pkg::CH_NEWLINE)
         return 1'b1;
      next_col = (r.char_code == tmte_pkg::CH_TAB) ? (cur_col / 4 + 1) * 4 : cur_col + 1;
      return next_col >= SCREEN_W;
   endfunction

   function automatic tmte_pkg::req_type make_req(logic [2:0] k, logic [7:0] ch,
                                                  logic [7:0] attr, logic [6:0] c,
                                                  logic [4:0] rw);
      tmte_pkg::req_type r;
      r.kind = k;
      r.char_code = ch;
      r.cell_colour = attr;
      r.column = c;
      r.row = rw;
      return r;
   endfunction

   function automatic tmte_pkg::req_type random_item();
      tmte_pkg::req_type r;
      int unsigned pick;
      r.char_code = 8'($urandom_range(0, 255));
      r.cell_colour = 8'($urandom_range(0, 255));
      r.column = 7'($urandom_range(0, 127));
      r.row = 5'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         r.kind = tmte_pkg::KIND_PUT_CHAR;
         case ($urandom_range(0, 9))
            0, 1: r.char_code = tmte_pkg::CH_NEWLINE;
            2: r.char_code = tmte_pkg::CH_TAB;
            default: ;
         endcase
      end else if (pick < 62) begin
         r.kind = tmte_pkg::KIND_PUT_AT;
      end else if (pick < 72) begin
         r.kind = tmte_pkg::KIND_MOVE;
      end else if (pick < 73) begin
         r.kind = tmte_pkg::KIND_CLEAR;
      end else if (pick < 95) begin
         r.kind = tmte_pkg::KIND_READ;
      end else begin
         r.kind = tmte_pkg::KIND_READ + 3'($urandom_range(1, 3));
      end
      if (r.kind != tmte_pkg::KIND_PUT_CHAR && $urandom_range(0, 7) != 0) begin
         r.column = 7'($urandom_range(0, SCREEN_W - 1));
         r.row = 5'($urandom_range(0, SCREEN_H - 1));
      end
      return r;
   endfunction

   task automatic queue_item(tmte_pkg::req_type r);
      terminal_job_type job;
      job.req = r;
      job.rsp = terminal_step(r);
      queued_items.push_back(job);
   endtask

   task automatic settle();
      @(negedge clock);
      while (queued_items.size() != 0 || start || due_results.size() != 0)
         @(negedge clock);
      repeat (SCREEN_WALK_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         pause_left = 0;
      end else begin
         if (start && !busy) begin
            due_results.push_back(on_port.rsp);
            if (calm_left > 0) begin
               calm_left--;
               pause_left = 0;
            end else begin
               pause_left = $urandom_range(0, 18);
               if ($urandom_range(0, 15) == 0)
                  calm_left = $urandom_range(10, 30);
            end
         end
         if (!start || !busy) begin
            if (pause_left > 0) begin
               pause_left--;
               start <= 1'b0;
            end else if (queued_items.size() != 0) begin
               on_port = queued_items.pop_front();
               req_item <= on_port.req;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      tmte_pkg::rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (due_results.size() == 0) begin
            report_mismatch("result with no item waiting", longint'(rsp_item), 0);
         end else begin
            want = due_results.pop_front();
            if (rsp_item.cursor_column !== want.cursor_column)
               report_mismatch("cursor_column", rsp_item.cursor_column, want.cursor_column);
            if (rsp_item.cursor_row !== want.cursor_row)
               report_mismatch("cursor_row", rsp_item.cursor_row, want.cursor_row);
            if (rsp_item.cursor_offset !== want.cursor_offset)
               report_mismatch("cursor_offset", rsp_item.cursor_offset, want.cursor_offset);
            if (rsp_item.cell_value !== want.cell_value)
               report_mismatch("cell_value", rsp_item.cell_value, want.cell_value);
         end
      end
   end

   initial begin
      tmte_pkg::req_type r;
      int phase;
      int walks_left;
      logic [7:0] next_colour;
      for (int i = 0; i < CELLS; i++)
         screen[i] = 16'h0000;
      cur_col = 0;
      cur_row = 0;
      text_colour = tmte_pkg::COLOUR_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_item(make_req(tmte_pkg::KIND_READ, 8'h00, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_PUT_CHAR, 8'h41, 8'hFF, 7'd127, 5'd31));
      queue_item(make_req(tmte_pkg::KIND_PUT_CHAR, tmte_pkg::CH_TAB, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_PUT_CHAR, tmte_pkg::CH_NEWLINE, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_PUT_AT, 8'hFF, 8'hFF, 7'd79, 5'd24));
      queue_item(make_req(tmte_pkg::KIND_READ, 8'h00, 8'h00, 7'd79, 5'd24));
      queue_item(make_req(tmte_pkg::KIND_PUT_AT, 8'h00, 8'h00, 7'd127, 5'd31));
      queue_item(make_req(tmte_pkg::KIND_READ, 8'hFF, 8'hFF, 7'd127, 5'd31));
      queue_item(make_req(tmte_pkg::KIND_READ, 8'h00, 8'h00, 7'd80, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_READ, 8'h00, 8'h00, 7'd0, 5'd25));
      queue_item(make_req(tmte_pkg::KIND_MOVE, 8'h00, 8'h00, 7'd127, 5'd31));
      queue_item(make_req(tmte_pkg::KIND_PUT_CHAR, 8'hFF, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_READ, 8'h00, 8'h00, 7'd79, 5'd23));
      queue_item(make_req(tmte_pkg::KIND_MOVE, 8'h00, 8'h00, 7'd76, 5'd24));
      queue_item(make_req(tmte_pkg::KIND_PUT_CHAR, tmte_pkg::CH_TAB, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_PUT_CHAR, tmte_pkg::CH_NEWLINE, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_READ + 3'd1, 8'hFF, 8'hFF, 7'd127, 5'd31));
      queue_item(make_req(tmte_pkg::KIND_READ + 3'd2, 8'h00, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_READ + 3'd3, 8'hAA, 8'h55, 7'd64, 5'd16));
      queue_item(make_req(tmte_pkg::KIND_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_READ, 8'h00, 8'h00, 7'd40, 5'd12));
      queue_item(make_req(tmte_pkg::KIND_PUT_CHAR, 8'h00, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_MOVE, 8'h00, 8'h00, 7'd78, 5'd10));
      queue_item(make_req(tmte_pkg::KIND_PUT_CHAR, tmte_pkg::CH_TAB, 8'h00, 7'd0, 5'd0));
      queue_item(make_req(tmte_pkg::KIND_PUT_AT, tmte_pkg::CH_NEWLINE, 8'h80, 7'd0, 5'd0));

      for (phase = 0; phase < 5; phase++) begin
         settle();
         case (phase)
            0: next_colour = 8'h00;
            1: next_colour = 8'hFF;
            3: next_colour = 8'h5A;
            default: next_colour = 8'($urandom_range(0, 255));
         endcase
         @(posedge clock);
         csr_we <= 1'b1;
         csr_wdata <= next_colour;
         @(posedge clock);
         csr_we <= 1'b0;
         text_colour = next_colour;
         @(negedge clock);
         walks_left = PHASE_WALKS;
         repeat (PHASE_ITEMS) begin
            r = random_item();
            if (walks_screen(r)) begin
               if (walks_left == 0) begin
                  r.kind = tmte_pkg::KIND_MOVE;
                  r.column = 7'($urandom_range(0, SCREEN_W - 1));
                  r.row = 5'($urandom_range(0, SCREEN_H - 2));
               end else begin
                  walks_left--;
               end
            end
            queue_item(r);
         end
      end

      settle();
      if (mismatches == 0)
         $display("tb_text_mode_terminal_engine_core: PASS");
      else
         $display("tb_text_mode_terminal_engine_core: FAIL");
      $finish;
   end

endmodule

// ===== text_mode_terminal_engine_core.f =====
src/tmte_pkg.sv
src/tmte_cursor.sv
src/text_mode_terminal_engine_core.sv
test/tb_text_mode_terminal_engine_core.sv
